// ===== sv/assert_macros.svh =====
// Assertion macros shared by the queue modules.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check prop at every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");
// Check that cond implies res in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) \
    else $error("%m: check failed");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, cond, res)
`endif
`endif

// ===== sv/laq_pkg.sv =====
// Shared types and constants for the linear array queue.
// No dependencies; used by every module of the block.
package laq_pkg;

  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int CNT_W     = 5;
  localparam int DEPTH_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_ENQ       = 2'd0,
    OP_DEQ       = 2'd1,
    OP_PEEK_HEAD = 2'd2,
    OP_PEEK_TAIL = 2'd3
  } laq_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } laq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_RESULT
  } laq_state_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] value;
  } laq_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic                     is_full;
  } laq_rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } laq_cmd_t;

endpackage

// ===== sv/laq_ctrl.sv =====
// Controller for the linear array queue: sequences load, store access, result.
// Depends on laq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module laq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output laq_pkg::laq_cmd_t cmd
);

  laq_pkg::laq_state_t state;
  laq_pkg::laq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= laq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    rsp_valid  = 1'b0;
    case (state)
      laq_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = laq_pkg::S_ACCESS;
        end
      end
      laq_pkg::S_ACCESS: begin
        cmd.exec   = 1'b1;
        state_next = laq_pkg::S_RESULT;
      end
      laq_pkg::S_RESULT: begin
        rsp_valid = 1'b1;
        // take the next item in the same edge the result leaves
        req_stall = rsp_stall;
        if (!rsp_stall) begin
          if (req_valid) begin
            cmd.load   = 1'b1;
            state_next = laq_pkg::S_ACCESS;
          end else begin
            state_next = laq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = laq_pkg::S_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_load_then_exec, clk, rst, cmd.load, cmd.exec)
  `ASSERT_CLK(a_load_on_accept, clk, rst, cmd.load |-> (req_valid && !req_stall))
  `ASSERT_NEXT(a_result_held, clk, rst, rsp_valid && rsp_stall, rsp_valid)

endmodule

// ===== sv/laq_datapath.sv =====
// Datapath for the linear array queue: indices, capacity, store and result.
// Depends on laq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module laq_datapath #(
  parameter int DEPTH = laq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  laq_pkg::laq_cmd_t           cmd,
  input  laq_pkg::laq_req_t           req,
  input  logic                        cfg_write,
  input  logic [laq_pkg::CAP_W-1:0]   cfg_data,
  output laq_pkg::laq_rsp_t           rsp
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = (IDX_W + 1 > laq_pkg::CAP_W) ? IDX_W + 1 : laq_pkg::CAP_W;
  localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

  logic [laq_pkg::DATA_W-1:0] store [DEPTH];

  logic [1:0]                 op;
  logic [laq_pkg::DATA_W-1:0] value;
  logic [IDX_W-1:0]           head_index;
  logic [IDX_W-1:0]           tail_index;
  logic                       holds_items;
  logic [laq_pkg::CAP_W-1:0]  capacity;
  logic [laq_pkg::DATA_W-1:0] rd_data;
  logic [1:0]                 res_status;
  logic [laq_pkg::CNT_W-1:0]  res_count;
  logic                       res_empty;
  logic                       res_full;

  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail_next;
  logic             holds_next;
  logic [1:0]       status_next;
  logic [EW-1:0]    cap_eff;
  logic [EW-1:0]    tail_inc;
  logic [EW-1:0]    tail_next_inc;
  logic [EW-1:0]    count_e;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  always_comb begin
    cap_eff = EW'(capacity);
    if (capacity == '0) begin
      cap_eff = EW'(1);
    end else if (EW'(capacity) > DEPTH_E) begin
      cap_eff = DEPTH_E;
    end
  end

  assign tail_inc = EW'(tail_index) + EW'(1);
  assign rd_addr  = (op == laq_pkg::OP_PEEK_TAIL) ? tail_index : head_index;

  always_comb begin
    head_next   = head_index;
    tail_next   = tail_index;
    holds_next  = holds_items;
    status_next = laq_pkg::ST_OK;
    wr_en       = 1'b0;
    wr_addr     = '0;
    if (op == laq_pkg::OP_ENQ) begin
      if (!holds_items) begin
        head_next  = '0;
        tail_next  = '0;
        holds_next = 1'b1;
        wr_en      = 1'b1;
      end else if (tail_inc < cap_eff) begin
        tail_next = tail_inc[IDX_W-1:0];
        wr_addr   = tail_inc[IDX_W-1:0];
        wr_en     = 1'b1;
      end else begin
        status_next = laq_pkg::ST_OVERFLOW;
      end
    end else if (!holds_items) begin
      status_next = laq_pkg::ST_UNDERFLOW;
    end else if (op == laq_pkg::OP_DEQ) begin
      // drained: rewind both indices
      if (head_index >= tail_index) begin
        head_next  = '0;
        tail_next  = '0;
        holds_next = 1'b0;
      end else begin
        head_next = head_index + IDX_W'(1);
      end
    end
  end

  assign tail_next_inc = EW'(tail_next) + EW'(1);
  assign count_e = holds_next ? (EW'(tail_next) - EW'(head_next) + EW'(1)) : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= req.operation;
      value <= req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) begin
        store[wr_addr] <= value;
      end
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= status_next;
      res_count  <= count_e[laq_pkg::CNT_W-1:0];
      res_empty  <= !holds_next;
      res_full   <= holds_next && (tail_next_inc == cap_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index  <= '0;
      tail_index  <= '0;
      holds_items <= 1'b0;
      capacity    <= laq_pkg::CAP_RESET;
    end else begin
      if (cmd.exec) begin
        head_index  <= head_next;
        tail_index  <= tail_next;
        holds_items <= holds_next;
      end
      if (cfg_write) begin
        capacity <= cfg_data;
      end
    end
  end

  always_comb begin
    rsp.status   = res_status;
    rsp.count    = res_count;
    rsp.is_empty = res_empty;
    rsp.is_full  = res_full;
    if (res_status == laq_pkg::ST_UNDERFLOW) begin
      rsp.data = '1;
    end else if (op == laq_pkg::OP_ENQ) begin
      rsp.data = '0;
    end else begin
      rsp.data = rd_data;
    end
  end

  `ASSERT_CLK(a_empty_rewound, clk, rst,
    !holds_items |-> (head_index == '0 && tail_index == '0))
  `ASSERT_CLK(a_head_not_past_tail, clk, rst, holds_items |-> head_index <= tail_index)
  `ASSERT_NEXT(a_enq_leaves_items, clk, rst, cmd.exec && op == laq_pkg::OP_ENQ, holds_items)

endmodule

// ===== sv/linear_array_queue.sv =====
// Top level of the linear array queue: controller plus datapath.
// Depends on laq_pkg, laq_ctrl and laq_datapath.
//
//   channel  signals                     carries
//   req      req_valid, req_stall, req   operation, value (laq_req_t)
//   rsp      rsp_valid, rsp_stall, rsp   data, status, count, flags (laq_rsp_t)
//   cfg      cfg_valid, cfg_ready, cfg_data   capacity register
//
// An item is accepted, reads or writes the store in the next cycle, and its
// result is shown in the cycle after that; no new item is taken before that
// result leaves.
// A new item is taken on the same edge that the previous result leaves.
// Synchronous reset empties the queue and sets capacity to 16; the store
// itself is not cleared and needs no clearing pass.
module linear_array_queue #(
  parameter int DEPTH = laq_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  laq_pkg::laq_req_t         req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output laq_pkg::laq_rsp_t         rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [laq_pkg::CAP_W-1:0] cfg_data
);

  laq_pkg::laq_cmd_t cmd;

  assign cfg_ready = 1'b1;

  laq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  laq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rsp       (rsp)
  );

endmodule
